// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

// ante implies cons in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/ledc_pkg.sv
// Shared types and constants of the ternary LED code generator.
// Used by ledc_build, ledc_store, the top level, the checker and the testbench; depends on nothing.
package ledc_pkg;

  localparam int LED_W    = 11;
  localparam int DIGITS_W = 24;
  localparam int VALUE_W  = 20;
  localparam int INDEX_W  = 10;
  localparam int RND_W    = 12;
  localparam int DCNT_W   = 4;
  localparam int LIM_W    = 13;

  localparam logic [LED_W-1:0]  LED_COUNT_RST  = 11'd150;
  localparam logic [LED_W-1:0]  TIER_SHORT_MAX = 11'd150;
  localparam logic [LED_W-1:0]  TIER_MID_MAX   = 11'd850;
  localparam logic [DCNT_W-1:0] DIGITS_SHORT   = 4'd8;
  localparam logic [DCNT_W-1:0] DIGITS_MID     = 4'd10;
  localparam logic [DCNT_W-1:0] DIGITS_LONG    = 4'd12;

  localparam logic MODE_RESTART = 1'b0;
  localparam logic MODE_ATTEMPT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic                done;
    logic [DIGITS_W-1:0] digits;
    logic [VALUE_W-1:0]  value;
  } build_res_t;

  typedef struct packed {
    logic done;
    logic match;
  } scan_res_t;

endpackage

// File: hw/rtl/ternary_led_code_generator.sv
// Ternary LED code generator, top level. One item in flight; the next is taken the cycle after
// the result register loads. Restart: build an N-digit row (N = 8, 10 or 12), then the result.
// Attempt: build, then scan the R stored rows, reading each row once, then the result.
// Full table: a refused attempt skips build and scan and goes straight to the result.
// rst_n is synchronous, active low: control state, row count, last row and
// led_count (to 150) reset; the code memory is not cleared and needs no pass.
module ternary_led_code_generator #(
  parameter int MAX_LEDS   = 1024,
  parameter int MAX_DIGITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [ledc_pkg::RND_W-1:0]    in_random_bits,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic                          out_duplicate,
  output logic [ledc_pkg::INDEX_W-1:0]  out_row_index,
  output logic [ledc_pkg::DIGITS_W-1:0] out_code_digits,
  output logic [ledc_pkg::VALUE_W-1:0]  out_code_value,
  output logic                          out_complete,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ledc_pkg::LED_W-1:0]    cfg_led_count
);

  localparam int AW = $clog2(MAX_LEDS);
  localparam int CW = $clog2(MAX_LEDS + 1);
  localparam logic [ledc_pkg::LIM_W-1:0]  MAX_LEDS_C   = ledc_pkg::LIM_W'(MAX_LEDS);
  localparam logic [ledc_pkg::DCNT_W-1:0] MAX_DIGITS_C = ledc_pkg::DCNT_W'(MAX_DIGITS);

  ledc_pkg::state_t state_r, state_nxt;

  logic [ledc_pkg::LED_W-1:0]    led_count_r;
  logic [CW-1:0]                 rows_r, rows_nxt;
  logic [ledc_pkg::DIGITS_W-1:0] last_row_r, last_row_nxt;
  logic                          mode_r;
  logic                          refuse_r, refuse_nxt;
  logic                          dup_r, dup_nxt;

  logic                          out_valid_r;
  logic                          acc_r, acc_nxt;
  logic                          odup_r, odup_nxt;
  logic [ledc_pkg::INDEX_W-1:0]  idx_r, idx_nxt;
  logic [ledc_pkg::DIGITS_W-1:0] dig_r, dig_nxt;
  logic [ledc_pkg::VALUE_W-1:0]  val_r, val_nxt;
  logic                          comp_r, comp_nxt;

  logic [ledc_pkg::DCNT_W-1:0]   ndig_base;
  logic [ledc_pkg::DCNT_W-1:0]   ndig;
  logic [ledc_pkg::LIM_W-1:0]    limit;
  logic                          full;
  logic                          in_acc;
  logic                          out_free;
  logic                          out_load;
  logic                          build_start;
  logic                          scan_start;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;

  ledc_pkg::build_res_t build_res;
  ledc_pkg::scan_res_t  scan_res;

  // digit count and effective row count follow led_count
  always_comb begin
    priority if (led_count_r <= ledc_pkg::TIER_SHORT_MAX) begin
      ndig_base = ledc_pkg::DIGITS_SHORT;
    end else if (led_count_r <= ledc_pkg::TIER_MID_MAX) begin
      ndig_base = ledc_pkg::DIGITS_MID;
    end else begin
      ndig_base = ledc_pkg::DIGITS_LONG;
    end
    ndig  = (ndig_base > MAX_DIGITS_C) ? MAX_DIGITS_C : ndig_base;
    limit = (ledc_pkg::LIM_W'(led_count_r) > MAX_LEDS_C) ? MAX_LEDS_C
                                                         : ledc_pkg::LIM_W'(led_count_r);
    full  = (ledc_pkg::LIM_W'(rows_r) >= limit);
  end

  assign in_stall  = (state_r != ledc_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt    = state_r;
    refuse_nxt   = refuse_r;
    dup_nxt      = dup_r;
    build_start  = 1'b0;
    scan_start   = 1'b0;
    out_load     = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = rows_r[AW-1:0];
    rows_nxt     = rows_r;
    last_row_nxt = last_row_r;
    acc_nxt      = 1'b0;
    odup_nxt     = 1'b0;
    idx_nxt      = '0;
    dig_nxt      = '0;
    val_nxt      = '0;
    comp_nxt     = 1'b1;

    unique case (state_r)
      ledc_pkg::ST_IDLE: begin
        if (in_acc) begin
          dup_nxt = 1'b0;
          if ((in_mode == ledc_pkg::MODE_ATTEMPT) && full) begin
            refuse_nxt = 1'b1;
            state_nxt  = ledc_pkg::ST_RESULT;
          end else begin
            refuse_nxt  = 1'b0;
            build_start = 1'b1;
            state_nxt   = ledc_pkg::ST_BUILD;
          end
        end
      end
      ledc_pkg::ST_BUILD: begin
        if (build_res.done) begin
          if (mode_r == ledc_pkg::MODE_RESTART) begin
            state_nxt = ledc_pkg::ST_RESULT;
          end else begin
            scan_start = 1'b1;
            state_nxt  = ledc_pkg::ST_SCAN;
          end
        end
      end
      ledc_pkg::ST_SCAN: begin
        if (scan_res.done) begin
          dup_nxt   = scan_res.match;
          state_nxt = ledc_pkg::ST_RESULT;
        end
      end
      ledc_pkg::ST_RESULT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ledc_pkg::ST_IDLE;
          if (!refuse_r) begin
            dig_nxt = build_res.digits;
            val_nxt = build_res.value;
            if (mode_r == ledc_pkg::MODE_RESTART) begin
              acc_nxt      = 1'b1;
              wr_en        = 1'b1;
              wr_addr      = '0;
              rows_nxt     = CW'(1);
              last_row_nxt = build_res.digits;
            end else if (dup_r) begin
              odup_nxt = 1'b1;
              idx_nxt  = ledc_pkg::INDEX_W'(rows_r);
            end else begin
              acc_nxt      = 1'b1;
              idx_nxt      = ledc_pkg::INDEX_W'(rows_r);
              wr_en        = 1'b1;
              rows_nxt     = rows_r + CW'(1);
              last_row_nxt = build_res.digits;
            end
            comp_nxt = (ledc_pkg::LIM_W'(rows_nxt) >= limit);
          end
        end
      end
      default: begin
        state_nxt = ledc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ledc_pkg::ST_IDLE;
      led_count_r <= ledc_pkg::LED_COUNT_RST;
      rows_r      <= '0;
      last_row_r  <= '0;
      out_valid_r <= 1'b0;
      refuse_r    <= 1'b0;
      dup_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rows_r     <= rows_nxt;
      last_row_r <= last_row_nxt;
      refuse_r   <= refuse_nxt;
      dup_r      <= dup_nxt;
      if (cfg_valid && cfg_ready) begin
        led_count_r <= cfg_led_count;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: hold while the result waits
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_mode;
    end
    if (out_load) begin
      acc_r  <= acc_nxt;
      odup_r <= odup_nxt;
      idx_r  <= idx_nxt;
      dig_r  <= dig_nxt;
      val_r  <= val_nxt;
      comp_r <= comp_nxt;
    end
  end

  ledc_build u_build (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (build_start),
    .restart     (in_mode == ledc_pkg::MODE_RESTART),
    .ndig        (ndig),
    .last_digits (last_row_r),
    .rnd         (in_random_bits),
    .res         (build_res)
  );

  ledc_store #(
    .MAX_LEDS (MAX_LEDS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .count   (rows_r),
    .value   (build_res.value),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (build_res.value),
    .res     (scan_res)
  );

  assign out_valid       = out_valid_r;
  assign out_accepted    = acc_r;
  assign out_duplicate   = odup_r;
  assign out_row_index   = idx_r;
  assign out_code_digits = dig_r;
  assign out_code_value  = val_r;
  assign out_complete    = comp_r;

endmodule

// File: hw/rtl/ledc_build.sv
// Digit-serial candidate builder: one ternary digit and one base-3 step per cycle.
// Depends on ledc_pkg.
module ledc_build (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          restart,
  input  logic [ledc_pkg::DCNT_W-1:0]   ndig,
  input  logic [ledc_pkg::DIGITS_W-1:0] last_digits,
  input  logic [ledc_pkg::RND_W-1:0]    rnd,
  output ledc_pkg::build_res_t          res
);

  logic                          busy_r;
  logic                          done_r;
  logic                          restart_r;
  logic [ledc_pkg::DCNT_W-1:0]   k_r;
  logic [ledc_pkg::DCNT_W-1:0]   ndig_r;
  logic [1:0]                    mod3_r;
  logic [1:0]                    prev_r;
  logic [ledc_pkg::DIGITS_W-1:0] last_r;
  logic [ledc_pkg::RND_W-1:0]    rnd_r;
  logic [ledc_pkg::DIGITS_W-1:0] digits_r;
  logic [ledc_pkg::VALUE_W-1:0]  value_r;

  logic [1:0]                    up;
  logic [1:0]                    other;
  logic [1:0]                    d;
  logic [ledc_pkg::DIGITS_W-1:0] digits_nxt;
  logic [ledc_pkg::VALUE_W-1:0]  value_nxt;

  // value different from a and b; with a == b the bit picks lower or higher
  function automatic logic [1:0] pick_digit(input logic [1:0] a, input logic [1:0] b,
                                            input logic bit_sel);
    logic [1:0] lo;
    logic [1:0] hi;
    lo = (a == 2'd0) ? 2'd1 : 2'd0;
    hi = (a == 2'd2) ? 2'd1 : 2'd2;
    if (a != b) begin
      return 2'd3 - a - b;
    end
    return bit_sel ? hi : lo;
  endfunction

  always_comb begin
    up         = 2'(last_r >> {k_r, 1'b0});
    other      = (k_r == '0) ? up : prev_r;
    d          = restart_r ? mod3_r : pick_digit(up, other, rnd_r[k_r]);
    digits_nxt = digits_r | (ledc_pkg::DIGITS_W'(d) << {k_r, 1'b0});
    value_nxt  = (value_r << 1) + value_r + ledc_pkg::VALUE_W'(d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (k_r == ndig_r - 4'd1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      restart_r <= restart;
      ndig_r    <= ndig;
      last_r    <= last_digits;
      rnd_r     <= rnd;
      k_r       <= '0;
      mod3_r    <= 2'd0;
      prev_r    <= 2'd0;
      digits_r  <= '0;
      value_r   <= '0;
    end else if (busy_r) begin
      k_r      <= k_r + 4'd1;
      mod3_r   <= (mod3_r == 2'd2) ? 2'd0 : mod3_r + 2'd1;
      prev_r   <= d;
      digits_r <= digits_nxt;
      value_r  <= value_nxt;
    end
  end

  assign res.done   = done_r;
  assign res.digits = digits_r;
  assign res.value  = value_r;

endmodule

// File: hw/rtl/ledc_store.sv
// Code memory with one write port and one registered read port, plus the
// duplicate scan that reads every stored row once. Depends on ledc_pkg.
module ledc_store #(
  parameter int MAX_LEDS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [$clog2(MAX_LEDS+1)-1:0]        count,
  input  logic [ledc_pkg::VALUE_W-1:0]         value,
  input  logic                                 wr_en,
  input  logic [$clog2(MAX_LEDS)-1:0]          wr_addr,
  input  logic [ledc_pkg::VALUE_W-1:0]         wr_data,
  output ledc_pkg::scan_res_t                  res
);

  localparam int AW = $clog2(MAX_LEDS);
  localparam int CW = $clog2(MAX_LEDS + 1);

  logic [ledc_pkg::VALUE_W-1:0] mem [MAX_LEDS];
  logic [ledc_pkg::VALUE_W-1:0] rdata_r;
  logic [CW-1:0]                idx_r;
  logic [CW-1:0]                count_r;
  logic                         busy_r;
  logic                         issue_r;
  logic                         chk_r;
  logic                         match_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      issue_r <= 1'b0;
      chk_r   <= 1'b0;
    end else if (start) begin
      busy_r  <= 1'b1;
      issue_r <= (count != '0);
      chk_r   <= 1'b0;
    end else if (busy_r) begin
      chk_r <= issue_r;
      if (issue_r && (idx_r + CW'(1) == count_r)) begin
        issue_r <= 1'b0;
      end
      if (!issue_r && !chk_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_r   <= '0;
      count_r <= count;
      match_r <= 1'b0;
    end else if (busy_r) begin
      if (issue_r) begin
        idx_r <= idx_r + CW'(1);
      end
      // compare the row whose address was issued in the cycle before
      if (chk_r && (rdata_r == value)) begin
        match_r <= 1'b1;
      end
    end
  end

  assign res.done  = busy_r && !issue_r && !chk_r;
  assign res.match = match_r;

endmodule

// File: hw/rtl/ledc_checker.sv
// Port-level checker for the ternary LED code generator, bound to the top level.
// Depends on ledc_pkg widths and assert_macros.svh.
`include "assert_macros.svh"

module ledc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_accepted,
  input logic                         out_duplicate,
  input logic [ledc_pkg::VALUE_W-1:0] out_code_value,
  input logic                         out_complete
);

  // a stalled result stays put
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_code_value))

  // a result is never both stored and rejected
  `ASSERT_NEVER(a_acc_dup_excl, out_valid && out_accepted && out_duplicate)

  // one item at a time: busy right after an accept
  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a refused attempt only happens on a full table
  `ASSERT_IMPL(a_refuse_complete, out_valid && !out_accepted && !out_duplicate, out_complete)

endmodule

bind ternary_led_code_generator ledc_checker u_ledc_checker (.*);

// File: dv/ternary_led_code_generator_tb.sv
// Self-checking testbench for ternary_led_code_generator: directed and random restart/attempt
// items, checked against an in-bench model of the code table, with led_count changes.
// Depends on ledc_pkg and the ternary_led_code_generator RTL only.
module ternary_led_code_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int TABLE_ROWS   = 1024;
  localparam int RANDOM_ITEMS = 560;
  localparam int HOLD_CYCLES  = 1500;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic                       mode;
    logic [ledc_pkg::RND_W-1:0] rnd;
  } led_item_t;

  typedef struct packed {
    logic                          accepted;
    logic                          duplicate;
    logic [ledc_pkg::INDEX_W-1:0]  row_index;
    logic [ledc_pkg::DIGITS_W-1:0] digits;
    logic [ledc_pkg::VALUE_W-1:0]  value;
    logic                          complete;
  } code_row_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_mode = ledc_pkg::MODE_RESTART;
  logic [ledc_pkg::RND_W-1:0]    in_random_bits = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_accepted;
  logic                          out_duplicate;
  logic [ledc_pkg::INDEX_W-1:0]  out_row_index;
  logic [ledc_pkg::DIGITS_W-1:0] out_code_digits;
  logic [ledc_pkg::VALUE_W-1:0]  out_code_value;
  logic                          out_complete;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ledc_pkg::LED_W-1:0]    cfg_led_count = ledc_pkg::LED_COUNT_RST;

  // model of the code table
  logic [ledc_pkg::LED_W-1:0]    model_led_count = ledc_pkg::LED_COUNT_RST;
  logic [ledc_pkg::VALUE_W-1:0]  stored_values [TABLE_ROWS];
  logic [ledc_pkg::DIGITS_W-1:0] prev_row_digits = '0;
  int                            rows_held = 0;

  led_item_t pending_items [$];
  code_row_t expected_rows [$];

  int  idle_pct = 33;
  int  stall_pct = 33;
  logic hold_off = 1'b0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  rows_added = 0;
  int  dup_rows = 0;
  int  refused_rows = 0;
  int  cfg_writes = 0;
  int  cycle_cnt = 0;

  ternary_led_code_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_random_bits  (in_random_bits),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_duplicate   (out_duplicate),
    .out_row_index   (out_row_index),
    .out_code_digits (out_code_digits),
    .out_code_value  (out_code_value),
    .out_complete    (out_complete),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_led_count   (cfg_led_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [ledc_pkg::VALUE_W-1:0] base3_of(
      input logic [ledc_pkg::DIGITS_W-1:0] packed_digits, input int ndig);
    int acc;
    acc = 0;
    for (int k = 0; k < ndig; k++) acc = acc * 3 + int'(packed_digits[2*k +: 2]);
    return ledc_pkg::VALUE_W'(acc);
  endfunction

  // Advance the table model by one item and return the row the block should emit.
  function automatic code_row_t predict_code_row(input logic mode,
                                                 input logic [ledc_pkg::RND_W-1:0] rnd);
    code_row_t                     r;
    int                            ndig;
    int                            limit;
    logic [ledc_pkg::DIGITS_W-1:0] cand;
    logic [1:0]                    d;
    logic [1:0]                    up;
    logic [1:0]                    prevd;
    logic [ledc_pkg::VALUE_W-1:0]  v;
    bit                            seen;
    r = '0;
    cand = '0;
    prevd = 2'd0;
    seen = 1'b0;
    if (model_led_count <= ledc_pkg::TIER_SHORT_MAX) ndig = int'(ledc_pkg::DIGITS_SHORT);
    else if (model_led_count <= ledc_pkg::TIER_MID_MAX) ndig = int'(ledc_pkg::DIGITS_MID);
    else ndig = int'(ledc_pkg::DIGITS_LONG);
    limit = (int'(model_led_count) > TABLE_ROWS) ? TABLE_ROWS : int'(model_led_count);

    if (mode == ledc_pkg::MODE_RESTART) begin
      for (int k = 0; k < ndig; k++) cand[2*k +: 2] = 2'(k % 3);
      v = base3_of(cand, ndig);
      stored_values[0] = v;
      prev_row_digits = cand;
      rows_held = 1;
      r.accepted = 1'b1;
      r.digits = cand;
      r.value = v;
      r.complete = (rows_held >= limit);
      return r;
    end

    // table full: refuse without touching state
    if (rows_held >= limit) begin
      r.complete = 1'b1;
      return r;
    end

    for (int k = 0; k < ndig; k++) begin
      up = prev_row_digits[2*k +: 2];
      if (k == 0) begin
        case (up)
          2'd0:    d = rnd[k] ? 2'd2 : 2'd1;
          2'd1:    d = rnd[k] ? 2'd2 : 2'd0;
          default: d = rnd[k] ? 2'd1 : 2'd0;
        endcase
      end else if (up != prevd) begin
        d = 2'(3 - int'(up) - int'(prevd));
      end else begin
        d = rnd[k] ? ((up == 2'd2) ? 2'd1 : 2'd2) : ((up == 2'd0) ? 2'd1 : 2'd0);
      end
      cand[2*k +: 2] = d;
      prevd = d;
    end
    v = base3_of(cand, ndig);

    for (int i = 0; i < rows_held; i++) begin
      if (stored_values[i] == v) seen = 1'b1;
    end

    r.digits = cand;
    r.value = v;
    if (seen) begin
      r.duplicate = 1'b1;
      r.row_index = ledc_pkg::INDEX_W'(rows_held);
    end else begin
      stored_values[rows_held] = v;
      prev_row_digits = cand;
      rows_held++;
      r.accepted = 1'b1;
      r.row_index = ledc_pkg::INDEX_W'(rows_held - 1);
    end
    r.complete = (rows_held >= limit);
    return r;
  endfunction

  // Input side: hold the item until taken, then maybe idle before the next one.
  always @(posedge clk) begin : drive_items
    led_item_t nxt;
    code_row_t want;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        want = predict_code_row(in_mode, in_random_bits);
        expected_rows.push_back(want);
        items_sent++;
        if (want.accepted) rows_added++;
        else if (want.duplicate) dup_rows++;
        else refused_rows++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_items.pop_front();
          in_valid <= 1'b1;
          in_mode <= nxt.mode;
          in_random_bits <= nxt.rnd;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_rows
    code_row_t got;
    code_row_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      got = {out_accepted, out_duplicate, out_row_index, out_code_digits, out_code_value,
             out_complete};
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: row result with none pending: row %0d value %h", $realtime,
                   got.row_index, got.value);
      end else begin
        want = expected_rows.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: row mismatch acc %b/%b dup %b/%b row %0d/%0d complete %b/%b",
                     $realtime, got.accepted, want.accepted, got.duplicate, want.duplicate,
                     got.row_index, want.row_index, got.complete, want.complete);
            $display("    digits %h/%h value %h/%h (got/expected)", got.digits, want.digits,
                     got.value, want.value);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("ternary_led_code_generator_tb: done, errors");
      $finish;
    end
  end

  // Hold the result side off for a long stretch so the block backs up its input.
  initial begin : hold_results
    wait (items_sent >= 150 && pending_items.size() >= 5);
    @(posedge clk);
    hold_off <= 1'b1;
    for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_rows.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_led_count(input logic [ledc_pkg::LED_W-1:0] lc);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_led_count <= lc;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_led_count = lc;
    cfg_writes++;
  endtask

  task automatic push_item(input logic mode, input logic [ledc_pkg::RND_W-1:0] rnd);
    pending_items.push_back({mode, rnd});
  endtask

  initial begin : stimulus
    int                         rand_left;
    int                         phase;
    int                         n_items;
    logic                       m;
    logic [ledc_pkg::LED_W-1:0] lc;
    rand_left = RANDOM_ITEMS;
    phase = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset count of 150: attempts before any restart, then rows from the restart pattern
    @(negedge clk);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'h000);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'hFFF);
    push_item(ledc_pkg::MODE_RESTART, 12'hFFF);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'h000);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'hFFF);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'hAAA);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'h555);
    push_item(ledc_pkg::MODE_RESTART, 12'h000);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'h3C3);
    wait_idle();

    // single row: complete at once, attempts refused
    write_led_count(11'd1);
    @(negedge clk);
    push_item(ledc_pkg::MODE_RESTART, 12'h000);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'hFFF);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'h000);
    push_item(ledc_pkg::MODE_RESTART, 12'hFFF);
    wait_idle();

    // grow to 10 digits on top of an 8-digit row
    write_led_count(11'd151);
    @(negedge clk);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'h3FF);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'hFFF);
    push_item(ledc_pkg::MODE_RESTART, 12'h000);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'h000);
    wait_idle();

    write_led_count(11'd851);
    @(negedge clk);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'hFFF);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'h000);
    push_item(ledc_pkg::MODE_RESTART, 12'h000);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'hFFF);
    wait_idle();

    write_led_count(11'd1024);
    @(negedge clk);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'hFFF);
    push_item(ledc_pkg::MODE_RESTART, 12'h000);
    wait_idle();

    // shrink back to 10 digits without a restart
    write_led_count(11'd850);
    @(negedge clk);
    push_item(ledc_pkg::MODE_ATTEMPT, 12'h000);

    while (rand_left > 0) begin
      case ($urandom_range(9))
        0, 1, 2, 3: lc = ledc_pkg::LED_W'($urandom_range(1, 16));
        4, 5:       lc = ledc_pkg::LED_W'($urandom_range(17, 150));
        6:          lc = ledc_pkg::LED_W'($urandom_range(151, 850));
        7:          lc = ledc_pkg::LED_W'($urandom_range(851, 1024));
        8: begin
          case ($urandom_range(7))
            0:       lc = 11'd1;
            1:       lc = 11'd2;
            2:       lc = 11'd150;
            3:       lc = 11'd151;
            4:       lc = 11'd850;
            5:       lc = 11'd851;
            6:       lc = 11'd1023;
            default: lc = 11'd1024;
          endcase
        end
        default:    lc = ledc_pkg::LED_W'($urandom_range(1, 1024));
      endcase
      wait_idle();
      write_led_count(lc);
      n_items = (phase == 2) ? 80 : $urandom_range(15, 50);
      if (n_items > rand_left) n_items = rand_left;
      @(negedge clk);
      // one long phase runs with no idling on either side
      idle_pct = (phase == 2) ? 0 : 33;
      stall_pct = (phase == 2) ? 0 : 33;
      for (int k = 0; k < n_items; k++) begin
        if (k == 0) begin
          m = ($urandom_range(99) < 80) ? ledc_pkg::MODE_RESTART : ledc_pkg::MODE_ATTEMPT;
        end else begin
          m = ($urandom_range(99) < 12) ? ledc_pkg::MODE_RESTART : ledc_pkg::MODE_ATTEMPT;
        end
        push_item(m, ledc_pkg::RND_W'($urandom_range(4095)));
      end
      rand_left -= n_items;
      phase++;
    end
    wait_idle();

    $display("ternary_led_code_generator_tb: %0d items over %0d led_count settings, %0d cycles",
             items_sent, cfg_writes + 1, cycle_cnt);
    $display("ternary_led_code_generator_tb: %0d rows stored, %0d duplicates, %0d refused, %0d bad",
             rows_added, dup_rows, refused_rows, mismatches);
    if (mismatches == 0) begin
      $display("ternary_led_code_generator_tb: done, clean");
    end else begin
      $display("ternary_led_code_generator_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: ternary_led_code_generator.f
+incdir+hw/rtl
hw/rtl/ledc_pkg.sv
hw/rtl/ledc_build.sv
hw/rtl/ledc_store.sv
hw/rtl/ternary_led_code_generator.sv
hw/rtl/ledc_checker.sv
dv/ternary_led_code_generator_tb.sv
